[rtl/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes for the breakpoint slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int unsigned SLOT_COUNT = 4;
  localparam int unsigned LIMIT_WIDTH = 64;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 64'h0000_8000_0000_0000;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [1:0] MODE_EXACT = 2'd0;
  localparam logic [1:0] MODE_INCL  = 2'd1;
  localparam logic [1:0] MODE_EXCL  = 2'd2;

  localparam logic [1:0] RANGE_NONE = 2'd0;

  localparam logic [2:0] SLOT_NONE = 3'd0;

  typedef struct packed {
    logic [1:0]            status;
    logic [2:0]            slot;
    logic [SLOT_COUNT-1:0] en_set;   // slots whose enable bit gets set
    logic [SLOT_COUNT-1:0] addr_wr;  // slots whose address gets written
    logic                  use_end;  // second slot of a pair takes the end address
    logic                  lo_range;
    logic                  hi_range;
    logic [1:0]            range_mode;
  } bsa_decision_t;

endpackage

`default_nettype wire

[rtl/bsa_decide.sv]
// ----------------------------------------------------------------------------
// bsa_decide
// Bounds check and slot choice for one breakpoint request.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_decide #(
  parameter int NUM_SLOTS = 4
) (
  input  wire logic [63:0]                      start_address,
  input  wire logic [63:0]                      end_address,
  input  wire logic [1:0]                       match_mode,
  input  wire logic [bsa_pkg::LIMIT_WIDTH-1:0]  address_limit,
  input  wire logic [bsa_pkg::SLOT_COUNT-1:0]   slot_enabled,
  input  wire logic [1:0]                       low_pair_range_mode,
  input  wire logic [1:0]                       high_pair_range_mode,
  output bsa_pkg::bsa_decision_t                decision
);

  logic [bsa_pkg::SLOT_COUNT-1:0] used;
  logic u1, u2, u3, u4;
  logic start_bad, end_bad;

  always_comb begin
    for (int i = 0; i < bsa_pkg::SLOT_COUNT; i++) begin
      used[i] = (i + 1 > NUM_SLOTS) || slot_enabled[i];
    end
    // a pair in range mode blocks its second slot too
    if (low_pair_range_mode != bsa_pkg::RANGE_NONE) used[1] = 1'b1;
    if (high_pair_range_mode != bsa_pkg::RANGE_NONE) used[3] = 1'b1;
  end

  assign u1 = used[0];
  assign u2 = used[1];
  assign u3 = used[2];
  assign u4 = used[3];

  assign start_bad = (start_address >= address_limit);
  assign end_bad   = (end_address >= address_limit);

  always_comb begin
    decision            = '0;
    decision.status     = bsa_pkg::ST_OK;
    decision.slot       = bsa_pkg::SLOT_NONE;
    decision.range_mode = (match_mode == bsa_pkg::MODE_EXCL) ? bsa_pkg::MODE_EXCL
                                                             : bsa_pkg::MODE_INCL;
    if (start_bad) begin
      decision.status = bsa_pkg::ST_BOUNDS;
    end else if (match_mode != bsa_pkg::MODE_EXACT) begin
      decision.use_end = 1'b1;
      if (end_bad) begin
        decision.status = bsa_pkg::ST_BOUNDS;
      end else if (!u1 && !u2) begin
        decision.slot     = 3'd1;
        decision.en_set   = 4'b0001;
        decision.addr_wr  = 4'b0011;
        decision.lo_range = 1'b1;
      end else if (!u3 && !u4) begin
        decision.slot     = 3'd3;
        decision.en_set   = 4'b0100;
        decision.addr_wr  = 4'b1100;
        decision.hi_range = 1'b1;
      end else begin
        decision.status = bsa_pkg::ST_FULL;
      end
    end else begin
      // take slot 2 before slot 1 when slot 2 is free and pair 3-4 is half used
      if (!u1 && (u2 || (u3 == u4))) begin
        decision.slot = 3'd1;
        decision.en_set = 4'b0001;
      end else if (!u2) begin
        decision.slot = 3'd2;
        decision.en_set = 4'b0010;
      end else if (!u3) begin
        decision.slot = 3'd3;
        decision.en_set = 4'b0100;
      end else if (!u4) begin
        decision.slot = 3'd4;
        decision.en_set = 4'b1000;
      end else begin
        decision.status = bsa_pkg::ST_FULL;
      end
      decision.addr_wr = decision.en_set;
    end
    if (decision.status != bsa_pkg::ST_OK) begin
      decision.slot     = bsa_pkg::SLOT_NONE;
      decision.en_set   = '0;
      decision.addr_wr  = '0;
      decision.lo_range = 1'b0;
      decision.hi_range = 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/breakpoint_slot_allocator_unit.sv]
// the slot decision is one combinational pass between the input and the result register
// throughput: one request per cycle unless m_tready stalls the result; each request sees
// the slot state left by the one before
// reset: all slots free, no range pairs, debug flag clear, address limit 0x0000800000000000
// ----------------------------------------------------------------------------
// breakpoint_slot_allocator_unit
// Allocates address-compare slots for exact and range breakpoint requests.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_slot_allocator_unit #(
  parameter int NUM_SLOTS  = 4,
  parameter int ADDR_WIDTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [63:0] start_address, [127:64] end_address, [129:128] match_mode, [135:130] zero
  input  wire logic [135:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [1:0] status, [4:2] slot_number, [7:5] zero
  output logic [7:0]        m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [63:0]  cfg_data
);

  logic                                 in_valid;
  logic [63:0]                          in_start;
  logic [63:0]                          in_end;
  logic [1:0]                           in_mode;
  logic                                 out_move;
  logic                                 step;

  logic [bsa_pkg::LIMIT_WIDTH-1:0]      address_limit;
  logic [ADDR_WIDTH-1:0]                slot_address [bsa_pkg::SLOT_COUNT];
  logic [bsa_pkg::SLOT_COUNT-1:0]       slot_enabled;
  logic [1:0]                           low_pair_range_mode;
  logic [1:0]                           high_pair_range_mode;
  logic                                 debug_active;

  logic [1:0]                           res_status;
  logic [2:0]                           res_slot;

  bsa_pkg::bsa_decision_t               decision;

  assign out_move  = !m_tvalid || m_tready;
  assign step      = in_valid && out_move;
  assign s_tready  = !in_valid || out_move;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_limit <= bsa_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      address_limit <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_start <= s_tdata[63:0];
      in_end   <= s_tdata[127:64];
      in_mode  <= s_tdata[129:128];
    end
  end

  bsa_decide #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_decide (
    .start_address        (in_start),
    .end_address          (in_end),
    .match_mode           (in_mode),
    .address_limit        (address_limit),
    .slot_enabled         (slot_enabled),
    .low_pair_range_mode  (low_pair_range_mode),
    .high_pair_range_mode (high_pair_range_mode),
    .decision             (decision)
  );

  // slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_enabled         <= '0;
      low_pair_range_mode  <= bsa_pkg::RANGE_NONE;
      high_pair_range_mode <= bsa_pkg::RANGE_NONE;
      debug_active         <= 1'b0;
    end else if (step && (decision.status == bsa_pkg::ST_OK)) begin
      slot_enabled <= slot_enabled | decision.en_set;
      debug_active <= 1'b1;
      if (decision.lo_range) low_pair_range_mode <= decision.range_mode;
      if (decision.hi_range) high_pair_range_mode <= decision.range_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bsa_pkg::SLOT_COUNT; i++) begin
        slot_address[i] <= '0;
      end
    end else if (step) begin
      for (int i = 0; i < bsa_pkg::SLOT_COUNT; i++) begin
        if (decision.addr_wr[i]) begin
          // second slot (odd index) of a range pair holds the end address
          if (decision.use_end && (i % 2 == 1)) begin
            slot_address[i] <= in_end[ADDR_WIDTH-1:0];
          end else begin
            slot_address[i] <= in_start[ADDR_WIDTH-1:0];
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_move) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_status <= decision.status;
      res_slot   <= decision.slot;
    end
  end

  assign m_tdata = {3'b000, res_slot, res_status};

endmodule

`default_nettype wire

[test/bsa_checker.sv]
// ----------------------------------------------------------------------------
// bsa_checker
// Watches the request, result and limit channels of the slot allocator,
// predicts each result from its own slot occupancy copy and compares.
// ----------------------------------------------------------------------------
module bsa_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [135:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [7:0]   m_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [63:0]  cfg_data,
  output int unsigned       fail_count,
  output int unsigned       pending_count,
  output int unsigned       granted_count,
  output int unsigned       bounds_count,
  output int unsigned       full_count
);

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
  } outcome_t;

  outcome_t expected_outcomes[$];

  // stored addresses and the debug flag have no port, so only occupancy is kept
  logic [63:0]                    limit_q;
  logic [bsa_pkg::SLOT_COUNT-1:0] slot_en;
  logic [1:0]                     low_pair_mode;
  logic [1:0]                     high_pair_mode;

  function automatic logic slot_busy(input int n);
    if (n > bsa_pkg::SLOT_COUNT) return 1'b1;
    if (slot_en[n-1]) return 1'b1;
    // second slot of a pair in range mode holds the end address
    if (n == 2 && low_pair_mode != bsa_pkg::RANGE_NONE) return 1'b1;
    if (n == 4 && high_pair_mode != bsa_pkg::RANGE_NONE) return 1'b1;
    return 1'b0;
  endfunction

  function automatic outcome_t allocate_slots(input logic [63:0] start_addr,
                                              input logic [63:0] end_addr,
                                              input logic [1:0]  mode);
    outcome_t   res;
    logic       u1, u2, u3, u4;
    logic [1:0] pair_mode;
    u1 = slot_busy(1);
    u2 = slot_busy(2);
    u3 = slot_busy(3);
    u4 = slot_busy(4);
    res.status = bsa_pkg::ST_OK;
    res.slot = bsa_pkg::SLOT_NONE;
    // the unused mode code behaves as inclusive
    pair_mode = (mode == bsa_pkg::MODE_EXCL) ? bsa_pkg::MODE_EXCL : bsa_pkg::MODE_INCL;
    if (start_addr >= limit_q) begin
      res.status = bsa_pkg::ST_BOUNDS;
    end else if (mode != bsa_pkg::MODE_EXACT) begin
      if (end_addr >= limit_q) begin
        res.status = bsa_pkg::ST_BOUNDS;
      end else if (!u1 && !u2) begin
        res.slot = 3'd1;
        slot_en[0] = 1'b1;
        low_pair_mode = pair_mode;
      end else if (!u3 && !u4) begin
        res.slot = 3'd3;
        slot_en[2] = 1'b1;
        high_pair_mode = pair_mode;
      end else begin
        res.status = bsa_pkg::ST_FULL;
      end
    end else begin
      // take slot 2 before slot 1 when slot 2 is free and pair 3-4 is already split
      if (!u1 && (u2 || u3 == u4)) res.slot = 3'd1;
      else if (!u2) res.slot = 3'd2;
      else if (!u3) res.slot = 3'd3;
      else if (!u4) res.slot = 3'd4;
      else res.status = bsa_pkg::ST_FULL;
      if (res.slot != bsa_pkg::SLOT_NONE) slot_en[res.slot - 3'd1] = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    outcome_t want;
    outcome_t got;
    int       errs;
    int       n_ok, n_bounds, n_full;
    errs = 0;
    n_ok = 0;
    n_bounds = 0;
    n_full = 0;
    if (rst) begin
      expected_outcomes.delete();
      limit_q = bsa_pkg::LIMIT_RESET;
      slot_en = '0;
      low_pair_mode = bsa_pkg::RANGE_NONE;
      high_pair_mode = bsa_pkg::RANGE_NONE;
      fail_count <= 0;
      pending_count <= 0;
      granted_count <= 0;
      bounds_count <= 0;
      full_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) limit_q = cfg_data;
      if (s_tvalid && s_tready) begin
        want = allocate_slots(s_tdata[63:0], s_tdata[127:64], s_tdata[129:128]);
        expected_outcomes.push_back(want);
        case (want.status)
          bsa_pkg::ST_OK:     n_ok = 1;
          bsa_pkg::ST_BOUNDS: n_bounds = 1;
          default:            n_full = 1;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.slot = m_tdata[4:2];
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d slot %0d",
                   $time, got.status, got.slot);
          errs++;
        end else begin
          want = expected_outcomes.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            errs++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: slot_number mismatch, expected %0d, got %0d",
                     $time, want.slot, got.slot);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= expected_outcomes.size();
      granted_count <= granted_count + n_ok;
      bounds_count <= bounds_count + n_bounds;
      full_count <= full_count + n_full;
    end
  end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives breakpoint requests and address limit writes into the slot
// allocator with random idle and backpressure; the checker judges results.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0]  MODE_ALIAS  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int          PHASE_ITEMS = 133;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // [63:0] start_address, [127:64] end_address, [129:128] match_mode, [135:130] zero
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [1:0] status, [4:2] slot_number, [7:5] zero
  logic [7:0]   m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [63:0]  cfg_data = '0;

  int unsigned fail_count, pending_count, granted_count, bounds_count, full_count;
  int unsigned cycle_count = 0;
  int unsigned request_count = 0;
  int unsigned limit_writes = 0;
  int          stall_left = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  logic [63:0] cur_limit = bsa_pkg::LIMIT_RESET;
  logic [63:0] limit_plan[6];

  breakpoint_slot_allocator_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  bsa_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .granted_count(granted_count), .bounds_count(bounds_count),
    .full_count(full_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("breakpoint_slot_allocator_unit verification failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      m_tready <= 1'b1;
    end
    if ($urandom_range(0, 199) == 0) rx_calm <= !rx_calm;
  end

  function automatic logic [63:0] pick_address();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return cur_limit - 64'd1;
      3: return cur_limit;
      4: return cur_limit + 64'($urandom_range(1, 3));
      5, 6: return {$urandom, $urandom};
      default: return (cur_limit == '0) ? {$urandom, $urandom}
                                         : {$urandom, $urandom} % cur_limit;
    endcase
  endfunction

  task automatic send_request(input logic [63:0] start_addr, input logic [63:0] end_addr,
                              input logic [1:0] mode);
    int idle;
    idle = (!tx_calm && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, mode, end_addr, start_addr};
    do @(posedge clk); while (!s_tready);
    request_count++;
  endtask

  // hold off new requests until every result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_limit(input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = value;
    limit_writes++;
  endtask

  initial begin
    limit_plan[0] = '0;
    limit_plan[1] = '1;
    limit_plan[2] = {$urandom, $urandom};
    limit_plan[3] = 64'd1;
    limit_plan[4] = 64'h0000_0001_0000_0000;
    limit_plan[5] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // bounds checks on the reset limit, then fill every slot
    send_request(bsa_pkg::LIMIT_RESET, '0, bsa_pkg::MODE_EXACT);
    send_request('0, bsa_pkg::LIMIT_RESET, bsa_pkg::MODE_INCL);
    send_request('1, '0, bsa_pkg::MODE_EXCL);
    send_request(bsa_pkg::LIMIT_RESET - 64'd1, '1, MODE_ALIAS);
    send_request(bsa_pkg::LIMIT_RESET + 64'd1, '0, bsa_pkg::MODE_EXACT);
    send_request('0, bsa_pkg::LIMIT_RESET - 64'd1, MODE_ALIAS);
    send_request(bsa_pkg::LIMIT_RESET - 64'd1, '1, bsa_pkg::MODE_EXACT);
    send_request(64'h1000, 64'h2000, bsa_pkg::MODE_EXCL);
    send_request(64'h1000, 64'h2000, bsa_pkg::MODE_INCL);
    send_request('0, '0, bsa_pkg::MODE_EXACT);
    send_request(64'h55AA_55AA, '0, bsa_pkg::MODE_EXACT);
    send_request(bsa_pkg::LIMIT_RESET, '0, bsa_pkg::MODE_EXACT);
    send_request(64'h10, bsa_pkg::LIMIT_RESET, bsa_pkg::MODE_EXCL);
    send_request(64'hAAAA_5555_AAAA, 64'h5555_AAAA_5555, MODE_ALIAS);
    drain_results();

    foreach (limit_plan[p]) begin
      write_limit(limit_plan[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        send_request(pick_address(), pick_address(), 2'($urandom_range(0, 3)));
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d requests across %0d address limit settings incl. zero and all ones",
             request_count, limit_writes + 1);
    $display("outcomes: %0d allocated, %0d out of bounds, %0d no free slot",
             granted_count, bounds_count, full_count);
    if (fail_count == 0) begin
      $display("breakpoint_slot_allocator_unit verification clean");
    end else begin
      $display("breakpoint_slot_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
